>>> sv/rbb_pkg.sv
// Shared types, constants and helpers of the region box blur block.
package rbb_pkg;

  // Default geometry limits handed to the top-level parameters.
  localparam int unsigned MAX_WIDTH_DEF  = 2048;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  // Pixel and window geometry.
  localparam int unsigned PIX_W = 8;
  localparam int unsigned RGB_W = 3 * PIX_W;
  localparam int unsigned WIN   = 3;
  localparam int unsigned TAPS  = WIN * WIN;

  // Configuration register widths.
  localparam int unsigned IMAGE_WIDTH_W   = 12;
  localparam int unsigned REGION_TOP_W    = 12;
  localparam int unsigned REGION_LEFT_W   = 11;
  localparam int unsigned REGION_BOTTOM_W = 13;
  localparam int unsigned REGION_RIGHT_W  = 12;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 13;

  localparam logic [IMAGE_WIDTH_W-1:0] IMAGE_WIDTH_RST = 12'd2048;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_REGION_TOP    = 3'd1,
    REG_REGION_LEFT   = 3'd2,
    REG_REGION_BOTTOM = 3'd3,
    REG_REGION_RIGHT  = 3'd4
  } cfg_reg_e;

  // Window sums and division by nine through a reciprocal multiply.
  // The sum of nine bytes stays below 2296, where this product is exact.
  localparam int unsigned SUM_W      = 12;
  localparam int unsigned DIV9_MUL   = 7282;
  localparam int unsigned DIV9_MUL_W = 13;
  localparam int unsigned DIV9_SHIFT = 16;
  localparam int unsigned PROD_W     = SUM_W + DIV9_MUL_W;

  // Result queue.
  localparam int unsigned OUT_FIFO_DEPTH = 8;
  localparam int unsigned FIFO_PTR_W     = $clog2(OUT_FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W     = $clog2(OUT_FIFO_DEPTH + 1);

  typedef logic [RGB_W-1:0] rgb_t;

  // Masked 3x3 window handed to the sum unit; taps are indexed column * 3 + row.
  typedef struct packed {
    logic                 blur_en;
    rgb_t                 center;
    rgb_t [TAPS-1:0]      taps;
  } blur_win_t;

  // Fill level of the result queue.
  typedef struct packed {
    logic [FIFO_CNT_W-1:0] count;
  } fifo_status_t;

  // Truncating division of a window sum by nine.
  function automatic logic [PIX_W-1:0] div9(input logic [SUM_W-1:0] s);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(s) * PROD_W'(DIV9_MUL);
    return prod[DIV9_SHIFT +: PIX_W];
  endfunction

endpackage

>>> sv/rbb_sum.sv
// Window sum and divide-by-nine unit of the region box blur block.
module rbb_sum (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  rbb_pkg::blur_win_t win_i,
  output logic              valid_o,
  output rbb_pkg::rgb_t     pix_o
);
  import rbb_pkg::*;

  logic [SUM_W-1:0] tap_b [WIN][TAPS];
  logic [SUM_W-1:0] sum_d [WIN];
  logic [SUM_W-1:0] sum_q [WIN];
  rgb_t             center_q;
  logic             blur_en_q;
  logic             valid_q;

  // Per-channel adder tree over the nine masked taps.
  always_comb begin
    for (int ch = 0; ch < WIN; ch++) begin
      for (int i = 0; i < TAPS; i++) begin
        tap_b[ch][i] = SUM_W'(win_i.taps[i][ch*PIX_W +: PIX_W]);
      end
      sum_d[ch] = ((tap_b[ch][0] + tap_b[ch][1]) + (tap_b[ch][2] + tap_b[ch][3])) +
                  ((tap_b[ch][4] + tap_b[ch][5]) + (tap_b[ch][6] + tap_b[ch][7])) +
                  tap_b[ch][8];
    end
  end

  // Sum stage valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Sum stage payload.
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      sum_q     <= sum_d;
      center_q  <= win_i.center;
      blur_en_q <= win_i.blur_en;
    end
  end

  // Pixels inside the rectangle take the quotient; others pass through.
  assign pix_o   = blur_en_q ? {div9(sum_q[2]), div9(sum_q[1]), div9(sum_q[0])} : center_q;
  assign valid_o = valid_q;

endmodule

>>> sv/rbb_out_fifo.sv
// Result queue that decouples the blur pipeline from output stalls.
module rbb_out_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  rbb_pkg::rgb_t         data_i,
  input  logic                  pop_i,
  output logic                  valid_o,
  output rbb_pkg::rgb_t         data_o,
  output rbb_pkg::fifo_status_t status_o
);
  import rbb_pkg::*;

  rgb_t                  slot_q [OUT_FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q;
  logic [FIFO_PTR_W-1:0] rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  pop;

  assign valid_o        = (cnt_q != '0);
  assign pop            = pop_i && valid_o;
  assign data_o         = slot_q[rd_ptr_q];
  assign status_o.count = cnt_q;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(OUT_FIFO_DEPTH - 1)) ? '0
                                                                  : wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(OUT_FIFO_DEPTH - 1)) ? '0
                                                                  : rd_ptr_q + FIFO_PTR_W'(1);
      end
      cnt_q <= cnt_q + FIFO_CNT_W'(push_i) - FIFO_CNT_W'(pop);
    end
  end

  // Slot storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> sv/region_box_blur_3x3.sv
// Top level of the region box blur: 3x3 blur of RGB pixels inside a rectangle.
//
//   Channel  | Handshake                 | Payload
//   ---------+---------------------------+------------------------------------------
//   input    | in_valid_i / in_ready_o   | red/green/blue_in_i, frame_start_i, filler_i
//   output   | out_valid_o / out_ready_i | red/green/blue_out_o
//   config   | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One input transaction per cycle is sustained while queue slots are free; the
// line store is a single read-modify-write memory with one read and one write
// port, and a write that collides with the next read of the same column is forwarded.
// A result passes from stage 1 through stage 2 and the sum stage into an
// eight-entry queue; input stalls only when that queue is spoken for.
// Reset clears counters, the window and all pipeline valids; the line store is not cleared.
module region_box_blur_3x3 #(
  parameter int unsigned MAX_WIDTH  = rbb_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = rbb_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Pixel input
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [rbb_pkg::PIX_W-1:0]       red_in_i,
  input  logic [rbb_pkg::PIX_W-1:0]       green_in_i,
  input  logic [rbb_pkg::PIX_W-1:0]       blue_in_i,
  input  logic                            frame_start_i,
  input  logic                            filler_i,
  // Pixel output
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [rbb_pkg::PIX_W-1:0]       red_out_o,
  output logic [rbb_pkg::PIX_W-1:0]       green_out_o,
  output logic [rbb_pkg::PIX_W-1:0]       blue_out_o,
  // Configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rbb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rbb_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import rbb_pkg::*;

  localparam int unsigned CW        = $clog2(MAX_WIDTH);
  localparam int unsigned RW        = $clog2(2 * MAX_HEIGHT);
  localparam int unsigned EW        = $clog2(MAX_WIDTH + 1);
  localparam int unsigned ROW_LIMIT = 2 * MAX_HEIGHT - 1;
  localparam int unsigned GW_A      = (RW > EW) ? RW : EW;
  localparam int unsigned GW        = ((GW_A > REGION_BOTTOM_W) ? GW_A : REGION_BOTTOM_W) + 2;
  localparam int unsigned RSV_W     = $clog2(OUT_FIFO_DEPTH + 1);

  // Configuration registers
  logic [IMAGE_WIDTH_W-1:0]   image_width_q;
  logic [REGION_TOP_W-1:0]    region_top_q;
  logic [REGION_LEFT_W-1:0]   region_left_q;
  logic [REGION_BOTTOM_W-1:0] region_bottom_q;
  logic [REGION_RIGHT_W-1:0]  region_right_q;

  // Position counters
  logic [CW-1:0] col_q, col_d, col_cur;
  logic [RW-1:0] row_q, row_d, row_cur;

  // Accept-side signals
  logic                 in_fire, out_fire;
  logic                 c_zero, emit0, col_end;
  rgb_t                 pix0;
  logic signed [GW-1:0] w_eff_g, top_g, left_g, bottom_g, right_g;
  logic signed [GW-1:0] col_g, row_g, cr0, cc0;

  // Stage 1: line store data arrives, window shifts, store is written back
  logic                 s1_valid_q;
  rgb_t                 s1_pix_q;
  logic [CW-1:0]        s1_idx_q;
  logic                 s1_czero_q;
  logic                 s1_emit_q;
  logic signed [GW-1:0] s1_cr_q, s1_cc_q;

  logic [2*RGB_W-1:0]   line_mem [MAX_WIDTH];
  logic [2*RGB_W-1:0]   line_rd_q;
  logic [2*RGB_W-1:0]   wr_data;
  logic                 fwd_hit;

  rgb_t                 win_q [WIN][WIN];
  rgb_t                 new_col [WIN];
  logic signed [GW-1:0] nb_row [WIN];
  logic signed [GW-1:0] nb_col [WIN];
  logic [WIN-1:0]       row_ok, col_ok;
  blur_win_t            blur_win;

  // Stage 2 and beyond
  logic                 s2_valid_q;
  blur_win_t            s2_win_q;
  logic                 res_valid;
  rgb_t                 res_pix;
  rgb_t                 fifo_data;
  fifo_status_t         fifo_status;
  logic [RSV_W-1:0]     rsv_q, rsv_d;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q   <= IMAGE_WIDTH_RST;
      region_top_q    <= '0;
      region_left_q   <= '0;
      region_bottom_q <= '0;
      region_right_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_IMAGE_WIDTH:   image_width_q   <= cfg_data_i[IMAGE_WIDTH_W-1:0];
        REG_REGION_TOP:    region_top_q    <= cfg_data_i[REGION_TOP_W-1:0];
        REG_REGION_LEFT:   region_left_q   <= cfg_data_i[REGION_LEFT_W-1:0];
        REG_REGION_BOTTOM: region_bottom_q <= cfg_data_i[REGION_BOTTOM_W-1:0];
        REG_REGION_RIGHT:  region_right_q  <= cfg_data_i[REGION_RIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective width is clamped to one at the low end and to the line store depth.
  always_comb begin
    if (image_width_q == '0) begin
      w_eff_g = GW'(1);
    end else if (GW'(image_width_q) > GW'(MAX_WIDTH)) begin
      w_eff_g = GW'(MAX_WIDTH);
    end else begin
      w_eff_g = GW'(image_width_q);
    end
  end

  assign top_g    = GW'(region_top_q);
  assign left_g   = GW'(region_left_q);
  assign bottom_g = GW'(region_bottom_q);
  assign right_g  = GW'(region_right_q);

  // Handshakes and reservation of queue slots for results in flight.
  assign in_ready_o = (rsv_q < RSV_W'(OUT_FIFO_DEPTH));
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_o && out_ready_i;
  assign rsv_d      = rsv_q + RSV_W'(in_fire && emit0) - RSV_W'(out_fire);

  // Position of this transaction and the window center it completes.
  always_comb begin
    col_cur = frame_start_i ? '0 : col_q;
    row_cur = frame_start_i ? '0 : row_q;
    col_g   = GW'(col_cur);
    row_g   = GW'(row_cur);
    c_zero  = (col_cur == '0);
    emit0   = (row_cur >= RW'(2)) || ((row_cur == RW'(1)) && !c_zero);
    cr0     = c_zero ? row_g - GW'(2) : row_g - GW'(1);
    cc0     = c_zero ? w_eff_g - GW'(1) : col_g - GW'(1);
    col_end = ((col_g + GW'(1)) >= w_eff_g);
    col_d   = col_end ? '0 : col_cur + CW'(1);
    row_d   = (col_end && (row_cur < RW'(ROW_LIMIT))) ? row_cur + RW'(1) : row_cur;
    pix0    = filler_i ? '0 : {blue_in_i, green_in_i, red_in_i};
  end

  // Control registers: counters, valids and reservations.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      rsv_q      <= '0;
    end else begin
      if (in_fire) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      s1_valid_q <= in_fire;
      s2_valid_q <= s1_valid_q && s1_emit_q;
      rsv_q      <= rsv_d;
    end
  end

  // Stage 1 payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q   <= pix0;
      s1_idx_q   <= col_cur;
      s1_czero_q <= c_zero;
      s1_emit_q  <= emit0;
      s1_cr_q    <= cr0;
      s1_cc_q    <= cc0;
    end
  end

  // Line store: upper half holds the row two up, lower half the row one up.
  assign wr_data = {line_rd_q[RGB_W-1:0], s1_pix_q};
  assign fwd_hit = in_fire && s1_valid_q && (col_cur == s1_idx_q);

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      line_mem[s1_idx_q] <= wr_data;
    end
    if (in_fire) begin
      line_rd_q <= fwd_hit ? wr_data : line_mem[col_cur];
    end
  end

  // New window column: row two up, row one up, current pixel.
  always_comb begin
    new_col[0] = line_rd_q[2*RGB_W-1:RGB_W];
    new_col[1] = line_rd_q[RGB_W-1:0];
    new_col[2] = s1_pix_q;
  end

  // Window shift register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WIN; k++) begin
        for (int j = 0; j < WIN; j++) begin
          win_q[k][j] <= '0;
        end
      end
    end else if (s1_valid_q) begin
      for (int j = 0; j < WIN; j++) begin
        win_q[0][j] <= win_q[1][j];
        win_q[1][j] <= win_q[2][j];
        win_q[2][j] <= new_col[j];
      end
    end
  end

  // Neighbor rows and columns inside the image and the rectangle.
  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      nb_row[i] = s1_cr_q + GW'(i) - GW'(1);
      nb_col[i] = s1_cc_q + GW'(i) - GW'(1);
      row_ok[i] = (nb_row[i] >= GW'(0)) && (nb_row[i] >= top_g) && (nb_row[i] < bottom_g);
      col_ok[i] = (nb_col[i] >= GW'(0)) && (nb_col[i] < w_eff_g) &&
                  (nb_col[i] >= left_g) && (nb_col[i] < right_g);
    end
  end

  // Masked window. At the start of a row the center is the last pixel of an
  // earlier row, so the right column is empty and the window has not shifted yet.
  always_comb begin
    for (int k = 0; k < WIN; k++) begin
      for (int j = 0; j < WIN; j++) begin
        if (!(row_ok[j] && col_ok[k])) begin
          blur_win.taps[k*WIN+j] = '0;
        end else if (k == 0) begin
          blur_win.taps[k*WIN+j] = win_q[1][j];
        end else if (k == 1) begin
          blur_win.taps[k*WIN+j] = win_q[2][j];
        end else begin
          blur_win.taps[k*WIN+j] = s1_czero_q ? '0 : new_col[j];
        end
      end
    end
    blur_win.center  = win_q[2][1];
    blur_win.blur_en = row_ok[1] && col_ok[1];
  end

  // Stage 2 payload.
  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_emit_q) begin
      s2_win_q <= blur_win;
    end
  end

  rbb_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid_q),
    .win_i   (s2_win_q),
    .valid_o (res_valid),
    .pix_o   (res_pix)
  );

  rbb_out_fifo u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (res_valid),
    .data_i   (res_pix),
    .pop_i    (out_ready_i),
    .valid_o  (out_valid_o),
    .data_o   (fifo_data),
    .status_o (fifo_status)
  );

  assign red_out_o   = fifo_data[PIX_W-1:0];
  assign green_out_o = fifo_data[2*PIX_W-1:PIX_W];
  assign blue_out_o  = fifo_data[3*PIX_W-1:2*PIX_W];

  // The queue is never pushed while full unless a slot frees in the same cycle.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> ((fifo_status.count < FIFO_CNT_W'(OUT_FIFO_DEPTH)) || out_fire))
    else $error("result queue overflow");

  // Every queued result was reserved when its transaction was accepted.
  a_rsv_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    RSV_W'(fifo_status.count) <= rsv_q)
    else $error("queued results exceed reservations");

  // A read of the column being written returns the written data.
  a_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit |=> (line_rd_q == $past(wr_data)))
    else $error("line store forwarding failed");

  // A result is offered only while a reservation is held.
  a_out_reserved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rsv_q != '0))
    else $error("result offered without reservation");

endmodule

>>> bench/rbb_checker.sv
// Checker for the region box blur: watches all three channels, predicts and compares results.
module rbb_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [rbb_pkg::PIX_W-1:0]       red_in_i,
  input  logic [rbb_pkg::PIX_W-1:0]       green_in_i,
  input  logic [rbb_pkg::PIX_W-1:0]       blue_in_i,
  input  logic                            frame_start_i,
  input  logic                            filler_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [rbb_pkg::PIX_W-1:0]       red_out_i,
  input  logic [rbb_pkg::PIX_W-1:0]       green_out_i,
  input  logic [rbb_pkg::PIX_W-1:0]       blue_out_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [rbb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rbb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output int unsigned                     fault_count_o,
  output int unsigned                     owed_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rbb_pkg::*;

  localparam int LINE_DEPTH = int'(MAX_WIDTH_DEF);
  localparam int ROW_CAP    = 2 * int'(MAX_HEIGHT_DEF) - 1;
  localparam int unsigned PRINT_CAP = 50;

  // Register copies.
  logic [IMAGE_WIDTH_W-1:0]   cfg_width;
  logic [REGION_TOP_W-1:0]    cfg_top;
  logic [REGION_LEFT_W-1:0]   cfg_left;
  logic [REGION_BOTTOM_W-1:0] cfg_bottom;
  logic [REGION_RIGHT_W-1:0]  cfg_right;

  // Predictor state: the two rows above, the 3x3 window and the next position.
  rgb_t row_above     [LINE_DEPTH];
  rgb_t row_two_above [LINE_DEPTH];
  rgb_t window_px     [WIN][WIN];   // [column old..new][row up..current]
  int   next_col;
  int   next_row;

  rgb_t        owed_pixels [$];
  int unsigned result_no;

  task automatic report_fault(input string msg);
    if (fault_count_o < PRINT_CAP) $display("%0t ns checker: %s", $time, msg);
    fault_count_o++;
  endtask

  // A position takes part in the blur only inside both the image and the rectangle.
  function automatic bit in_blur_rect(input int r, input int c, input int w);
    if (r < 0 || c < 0 || c >= w) return 1'b0;
    return r >= int'(cfg_top) && r < int'(cfg_bottom) &&
           c >= int'(cfg_left) && c < int'(cfg_right);
  endfunction

  // Truncated sum of the counted taps divided by nine, or the center when it lies outside.
  function automatic rgb_t region_mean(input rgb_t [TAPS-1:0] taps, input int cr,
                                       input int cc, input int w);
    int unsigned sum_r, sum_g, sum_b;
    int          k, j;
    rgb_t        mean;
    if (!in_blur_rect(cr, cc, w)) return taps[WIN + 1];
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    for (k = 0; k < WIN; k++) begin
      for (j = 0; j < WIN; j++) begin
        if (in_blur_rect(cr - 1 + j, cc - 1 + k, w)) begin
          sum_r += taps[k*WIN + j][0 +: PIX_W];
          sum_g += taps[k*WIN + j][PIX_W +: PIX_W];
          sum_b += taps[k*WIN + j][2*PIX_W +: PIX_W];
        end
      end
    end
    mean[0 +: PIX_W]       = PIX_W'(sum_r / TAPS);
    mean[PIX_W +: PIX_W]   = PIX_W'(sum_g / TAPS);
    mean[2*PIX_W +: PIX_W] = PIX_W'(sum_b / TAPS);
    return mean;
  endfunction

  // Advance the predictor by one input transaction and queue the result it owes.
  task automatic predict_output_pixel(input rgb_t px_in, input logic fs, input logic fill);
    int               w, r, c, cr, cc, idx, k, j;
    logic             emit;
    rgb_t             px;
    rgb_t [TAPS-1:0]  taps;
    w = int'(cfg_width);
    if (w < 1) w = 1;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    if (fs) begin
      next_col = 0;
      next_row = 0;
    end
    px   = fill ? '0 : px_in;
    r    = next_row;
    c    = next_col;
    idx  = (c < LINE_DEPTH) ? c : LINE_DEPTH - 1;
    emit = (r >= 2) || (r == 1 && c >= 1);
    cr   = r - 1;
    cc   = c - 1;
    taps = '0;
    // At the start of a row the center is the last pixel two rows up, taken from
    // the window before it shifts; its right-hand column lies past the edge.
    if (c == 0) begin
      for (j = 0; j < WIN; j++) begin
        taps[j]       = window_px[1][j];
        taps[WIN + j] = window_px[2][j];
      end
      cr = r - 2;
      cc = w - 1;
    end
    for (j = 0; j < WIN; j++) begin
      window_px[0][j] = window_px[1][j];
      window_px[1][j] = window_px[2][j];
    end
    window_px[2][0]    = row_two_above[idx];
    window_px[2][1]    = row_above[idx];
    window_px[2][2]    = px;
    row_two_above[idx] = row_above[idx];
    row_above[idx]     = px;
    if (c != 0) begin
      for (k = 0; k < WIN; k++) begin
        for (j = 0; j < WIN; j++) taps[k*WIN + j] = window_px[k][j];
      end
    end
    if (emit) owed_pixels.insert(owed_pixels.size(), region_mean(taps, cr, cc, w));
    if (c + 1 >= w) begin
      next_col = 0;
      if (next_row < ROW_CAP) next_row++;
    end else begin
      next_col = c + 1;
    end
  endtask

  // Monitor all channels at each rising edge.
  always @(posedge clk_i) begin
    rgb_t want;
    if (!rst_ni) begin
      cfg_width  = IMAGE_WIDTH_RST;
      cfg_top    = '0;
      cfg_left   = '0;
      cfg_bottom = '0;
      cfg_right  = '0;
      for (int i = 0; i < LINE_DEPTH; i++) begin
        row_above[i]     = '0;
        row_two_above[i] = '0;
      end
      for (int i = 0; i < WIN; i++) begin
        for (int j = 0; j < WIN; j++) window_px[i][j] = '0;
      end
      next_col      = 0;
      next_row      = 0;
      result_no     = 0;
      fault_count_o = 0;
      owed_pixels.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_IMAGE_WIDTH:   cfg_width  = cfg_data_i[IMAGE_WIDTH_W-1:0];
          REG_REGION_TOP:    cfg_top    = cfg_data_i[REGION_TOP_W-1:0];
          REG_REGION_LEFT:   cfg_left   = cfg_data_i[REGION_LEFT_W-1:0];
          REG_REGION_BOTTOM: cfg_bottom = cfg_data_i[REGION_BOTTOM_W-1:0];
          REG_REGION_RIGHT:  cfg_right  = cfg_data_i[REGION_RIGHT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        predict_output_pixel({blue_in_i, green_in_i, red_in_i}, frame_start_i, filler_i);
      end
      // Compare each delivered pixel with the oldest owed one.
      if (out_valid_i && out_ready_i) begin
        if (owed_pixels.size() == 0) begin
          report_fault($sformatf("result %0d arrived with nothing owed", result_no));
        end else begin
          want = owed_pixels.pop_front();
          if (red_out_i !== want[0 +: PIX_W])
            report_fault($sformatf("result %0d red %02h, expected %02h",
                                   result_no, red_out_i, want[0 +: PIX_W]));
          if (green_out_i !== want[PIX_W +: PIX_W])
            report_fault($sformatf("result %0d green %02h, expected %02h",
                                   result_no, green_out_i, want[PIX_W +: PIX_W]));
          if (blue_out_i !== want[2*PIX_W +: PIX_W])
            report_fault($sformatf("result %0d blue %02h, expected %02h",
                                   result_no, blue_out_i, want[2*PIX_W +: PIX_W]));
        end
        result_no++;
      end
    end
    owed_count_o <= owed_pixels.size();
  end

endmodule

>>> bench/tb_region_box_blur_3x3.sv
// Testbench top for the region box blur: clock, reset, stimulus and the verdict.
module tb_region_box_blur_3x3;
  timeunit 1ns;
  timeprecision 1ps;
  import rbb_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 880;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned LONG_HOLD     = 150;
  localparam int          PRELOAD_W     = 64;
  localparam int          TAIL_W        = 8;
  localparam int          TAIL_ROWS     = 5;
  localparam longint     RUN_LIMIT_NS   = 5_000_000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [PIX_W-1:0]      red_in_i;
  logic [PIX_W-1:0]      green_in_i;
  logic [PIX_W-1:0]      blue_in_i;
  logic                  frame_start_i;
  logic                  filler_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [PIX_W-1:0]      red_out_o;
  logic [PIX_W-1:0]      green_out_o;
  logic [PIX_W-1:0]      blue_out_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int unsigned fault_count;
  int unsigned owed_count;
  bit          quiet;
  int unsigned hold_requests;

  region_box_blur_3x3 DUT (.*);

  rbb_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .red_in_i      (red_in_i),
    .green_in_i    (green_in_i),
    .blue_in_i     (blue_in_i),
    .frame_start_i (frame_start_i),
    .filler_i      (filler_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .red_out_i     (red_out_o),
    .green_out_i   (green_out_o),
    .blue_out_i    (blue_out_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fault_count_o (fault_count),
    .owed_count_o  (owed_count)
  );

  always #5 clk_i = ~clk_i;

  // Offer one pixel transaction, after an occasional idle burst.
  task automatic send_pixel(input rgb_t px, input logic fs, input logic fill);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    red_in_i      <= px[0 +: PIX_W];
    green_in_i    <= px[PIX_W +: PIX_W];
    blue_in_i     <= px[2*PIX_W +: PIX_W];
    frame_start_i <= fs;
    filler_i      <= fill;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic flush(input int unsigned count);
    repeat (count) send_pixel(rgb_t'($urandom), 1'b0, 1'b1);
  endtask

  // Stop offering, wait until every owed result is out, then let the pipeline settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (owed_count != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int unsigned value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_DATA_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Result side: random stall bursts, plus one long hold-off per request.
  initial begin
    int unsigned hold_left;
    int unsigned holds_served;
    hold_left    = 0;
    holds_served = 0;
    out_ready_i  = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (holds_served != hold_requests) begin
        holds_served++;
        hold_left   = LONG_HOLD - 1;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        hold_left   = $urandom_range(0, 2);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int unsigned sent, rows, n_pix, w_cfg, w_now, resize_at, noise;
    bit          first, restart;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    red_in_i      = '0;
    green_in_i    = '0;
    blue_in_i     = '0;
    frame_start_i = 1'b0;
    filler_i      = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_IMAGE_WIDTH;
    cfg_data_i    = '0;
    quiet         = 1'b0;
    hold_requests = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // One row blurred everywhere; the flush row writes every column used below
    // once more, so both line stores hold known data from here on.
    write_reg(REG_IMAGE_WIDTH, PRELOAD_W);
    write_reg(REG_REGION_BOTTOM, 4096);
    write_reg(REG_REGION_RIGHT, 2048);
    for (int p = 0; p < PRELOAD_W; p++) begin
      send_pixel(p == 0 ? rgb_t'(0) : p == 1 ? '1 : rgb_t'($urandom), p == 0, 1'b0);
    end
    flush(PRELOAD_W + 1);
    drain();

    // Small frame: interior rectangle, filler inside the image, restart mid-row.
    write_reg(REG_IMAGE_WIDTH, 4);
    write_reg(REG_REGION_TOP, 0);
    write_reg(REG_REGION_LEFT, 1);
    write_reg(REG_REGION_BOTTOM, 2);
    write_reg(REG_REGION_RIGHT, 3);
    send_pixel('0, 1'b1, 1'b0);
    repeat (3) send_pixel('1, 1'b0, 1'b0);
    send_pixel('1, 1'b0, 1'b1);
    send_pixel(24'hFF00FF, 1'b0, 1'b0);
    send_pixel(24'h00FF00, 1'b1, 1'b0);
    for (int p = 1; p < 12; p++) begin
      send_pixel(p % 3 == 0 ? rgb_t'(0) : p % 3 == 1 ? '1 : rgb_t'($urandom), 1'b0, 1'b0);
    end
    flush(5);
    drain();

    // Random frames with random geometry; the first one also fills the result queue.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      first = (sent == 0);
      case ($urandom_range(0, 9))
        0:       w_cfg = 0;
        1:       w_cfg = $urandom_range(9, 40);
        default: w_cfg = $urandom_range(1, 8);
      endcase
      if (first) w_cfg = 8;
      rows = first ? 6 : $urandom_range(1, 6);
      write_reg(REG_IMAGE_WIDTH, w_cfg);
      w_now = (w_cfg == 0) ? 1 : w_cfg;
      if (first || $urandom_range(0, 2) != 0)
        write_reg(REG_REGION_TOP, $urandom_range(0, 7) == 0 ?
                  ($urandom_range(0, 1) ? 4095 : 0) : $urandom_range(0, rows));
      if (first || $urandom_range(0, 2) != 0)
        write_reg(REG_REGION_LEFT, $urandom_range(0, 7) == 0 ?
                  ($urandom_range(0, 1) ? 2047 : 0) : $urandom_range(0, w_now));
      if (first || $urandom_range(0, 2) != 0)
        write_reg(REG_REGION_BOTTOM, $urandom_range(0, 7) == 0 ?
                  ($urandom_range(0, 1) ? 4096 : 0) : $urandom_range(0, rows + 1));
      if (first || $urandom_range(0, 2) != 0)
        write_reg(REG_REGION_RIGHT, $urandom_range(0, 7) == 0 ?
                  ($urandom_range(0, 1) ? 2048 : 0) : $urandom_range(0, w_now + 1));
      n_pix     = rows * w_now;
      restart   = first || $urandom_range(0, 5) != 0;
      resize_at = (!first && $urandom_range(0, 3) == 0) ? $urandom_range(1, n_pix) : n_pix;
      if (first) hold_requests++;
      for (int unsigned p = 0; p < n_pix; p++) begin
        // Occasionally change the width in the middle of a frame.
        if (p == resize_at) begin
          drain();
          w_now = $urandom_range(1, 8);
          write_reg(REG_IMAGE_WIDTH, w_now);
        end
        noise = $urandom_range(0, 39);
        send_pixel(rgb_t'($urandom), (p == 0 && restart) || noise == 0, noise == 1);
      end
      flush(w_now + 1);
      sent += n_pix + w_now + 1;
      drain();
    end

    // Last frame blurred everywhere, with no idling on either side.
    quiet = 1'b1;
    write_reg(REG_IMAGE_WIDTH, TAIL_W);
    write_reg(REG_REGION_TOP, 0);
    write_reg(REG_REGION_BOTTOM, 4096);
    write_reg(REG_REGION_LEFT, 0);
    write_reg(REG_REGION_RIGHT, 2048);
    for (int p = 0; p < TAIL_W * TAIL_ROWS; p++) send_pixel(rgb_t'($urandom), p == 0, 1'b0);
    flush(TAIL_W + 1);
    drain();

    if (fault_count == 0 && owed_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(RUN_LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

endmodule
